FILE: hw/rtl/olpi_pkg.sv
// Shared constants for the ordered list with positional insert.
// No dependencies; imported by the RAM-using top level and its checker.
package olpi_pkg;

	// Default list depth
	localparam int CAPACITY_DEF = 32;

	// Field widths
	localparam int POS_W  = 7;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_ELEMENT = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

	// Position code for append at the tail (-1 in seven bits)
	localparam logic [POS_W-1:0] POS_APPEND = 7'h7F;

endpackage

FILE: hw/rtl/olpi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies. Read data holds while the read enable is low.
module olpi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/ordered_list_positional_insert.sv
// Ordered list with positional insert, values held in one RAM.
// Operation: an insert at position p into a list of n first shifts entries p..n-1 up one place
// (none for an append), then writes the value at p, then sends 2*(n+1) output words, a forward
// pass then a reverse pass. Errors (bad position, full list) give a single word from the error state.
// Throughput: one item at a time; the RAM's single write port sets the shift rate.
// Reset clears the count and control; RAM contents are not cleared.
module ordered_list_positional_insert import olpi_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [POS_W-1:0]  position,
	input  logic signed [VAL_W-1:0]  value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [STAT_W-1:0]        status,
	output logic                     direction,
	output logic signed [VAL_W-1:0]  element,
	output logic                     last
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int K_W    = CNT_W + 1;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SHIFT = 4'b0010,
		S_EMIT  = 4'b0100,
		S_ERR   = 4'b1000
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    ptr_q;
	logic [K_W-1:0]      k_q;
	logic [K_W-1:0]      total_q;
	logic [STAT_W-1:0]   err_q;
	logic [VAL_W-1:0]    value_q;
	logic                pend_s1;
	logic [ADDR_W-1:0]   waddr_s1;
	logic                dir_s1;
	logic                last_s1;
	logic                out_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic                direction_q;
	logic [VAL_W-1:0]    element_q;
	logic                last_q;

	logic [POS_W-1:0]    pos_raw;
	logic                pos_append;
	logic                pos_bad;
	logic                is_full;
	logic [CNT_W-1:0]    pos_idx;
	logic [CNT_W-1:0]    cnt_next;
	logic                in_take;
	logic                out_free;
	logic                shift_issue;
	logic                emit_issue;
	logic                emit_load;
	logic                err_load;
	logic                k_lo;
	logic                emit_done;
	logic [ADDR_W-1:0]   emit_addr;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [VAL_W-1:0]    ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [VAL_W-1:0]    ram_rdata;

	// position decode against the current count
	assign pos_raw    = position;
	assign pos_append = (pos_raw == POS_APPEND);
	assign pos_bad    = !pos_append &&
		(pos_raw[POS_W-1] || (pos_raw > POS_W'(count_q)));
	assign is_full    = (count_q == CAP_CNT);
	assign pos_idx    = pos_append ? count_q : CNT_W'(pos_raw);
	assign cnt_next   = count_q + CNT_W'(1);

	// handshakes
	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// shift: read entry ptr-1, write it to ptr in the following cycle
	assign shift_issue = (state_q == S_SHIFT) && (ptr_q > idx_q);

	// output sweep: forward pass, then reverse pass
	assign k_lo       = (k_q < K_W'(count_q));
	assign emit_addr  = k_lo ? ADDR_W'(k_q) : ADDR_W'(total_q - k_q - K_W'(1));
	assign emit_done  = (k_q == total_q);
	assign emit_issue = (state_q == S_EMIT) && !emit_done && (!pend_s1 || out_free);
	assign emit_load  = (state_q == S_EMIT) && pend_s1 && out_free;
	assign err_load   = (state_q == S_ERR) && out_free;

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = waddr_s1;
		ram_wdata = ram_rdata;
		if (state_q == S_SHIFT) begin
			if (pend_s1) begin
				ram_we = 1'b1;
			end else if (!shift_issue) begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[ADDR_W-1:0];
				ram_wdata = value_q;
			end
		end
	end

	assign ram_re    = shift_issue || emit_issue;
	assign ram_raddr = shift_issue ? ADDR_W'(ptr_q - CNT_W'(1)) : emit_addr;

	olpi_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			ptr_q   <= '0;
			k_q     <= '0;
			total_q <= '0;
			err_q   <= ST_ELEMENT;
			pend_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (in_take) begin
						if (pos_bad) begin
							err_q   <= ST_INVALID;
							state_q <= S_ERR;
						end else if (is_full) begin
							err_q   <= ST_FULL;
							state_q <= S_ERR;
						end else begin
							idx_q   <= pos_idx;
							ptr_q   <= count_q;
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					pend_s1 <= shift_issue;
					if (shift_issue) begin
						ptr_q <= ptr_q - CNT_W'(1);
					end else if (!pend_s1) begin
						count_q <= cnt_next;
						total_q <= {cnt_next, 1'b0};
						k_q     <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_issue) begin
						pend_s1 <= 1'b1;
						k_q     <= k_q + K_W'(1);
					end else if (emit_load) begin
						pend_s1 <= 1'b0;
					end
					if (emit_done && (!pend_s1 || out_free)) begin
						state_q <= S_IDLE;
					end
				end
				S_ERR: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload side of the pipeline
	always_ff @(posedge clk) begin
		if (in_take) begin
			value_q <= value;
		end
		if (shift_issue) begin
			waddr_s1 <= ptr_q[ADDR_W-1:0];
		end
		if (emit_issue) begin
			dir_s1  <= !k_lo;
			last_s1 <= (k_q == total_q - K_W'(1));
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (err_load || emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (err_load) begin
			status_q    <= err_q;
			direction_q <= 1'b0;
			element_q   <= '0;
			last_q      <= 1'b1;
		end else if (emit_load) begin
			status_q    <= ST_ELEMENT;
			direction_q <= dir_s1;
			element_q   <= ram_rdata;
			last_q      <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign direction = direction_q;
	assign element   = $signed(element_q);
	assign last      = last_q;

endmodule

FILE: hw/rtl/olpi_checker.sv
// Port-level checks for the ordered list with positional insert, bound to the top.
// Depends on olpi_pkg for field widths and status codes.
module olpi_checker import olpi_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [STAT_W-1:0]       status,
	input logic                    direction,
	input logic signed [VAL_W-1:0] element,
	input logic                    last
);

	// one item at a time: input closes right after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after an accept");

	// error words are single, zero and forward
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_ELEMENT) |-> (last && element == 0 && !direction))
		else $error("malformed error word");

	// the forward pass never ends an item's output
	a_fwd_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_ELEMENT && !direction) |-> !last)
		else $error("forward word flagged last");

	// stalled output word holds its element, status and last flag
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(element) && $stable(status) && $stable(last)))
		else $error("stalled output word changed");

endmodule

bind ordered_list_positional_insert olpi_checker u_olpi_checker (.*);
